### hdl/quad_grid_point_warp_macros.svh
// assertion macros used by the warp sequencer (qgpw_ctrl)
`ifndef QUAD_GRID_POINT_WARP_MACROS_SVH
`define QUAD_GRID_POINT_WARP_MACROS_SVH

`ifndef SYNTHESIS
`define QGPW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QGPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QGPW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define QGPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/qgpw_pkg.sv
// ----------------------------------------------------------------------------
// qgpw_pkg
// types and constants shared by the quad grid point warp modules
// ----------------------------------------------------------------------------
package qgpw_pkg;

   localparam int GRID_ROWS    = 4;
   localparam int GRID_COLS    = 8;
   localparam int CELL_COUNT   = GRID_ROWS * GRID_COLS;
   localparam int CORNER_COUNT = CELL_COUNT * 4;
   localparam int CELL_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int ADDR_W       = CELL_W + 2;
   localparam int CNT_W        = (ADDR_W > 5) ? ADDR_W : 5;
   localparam int DIV_STEPS    = 17;
   localparam int W_W          = 34;   // signed corner weight
   localparam int WU_W         = 33;   // non-negative corner weight
   localparam int DEN_W        = 34;
   localparam int REM_W        = 36;
   localparam int Q_W          = 17;
   localparam int ACC_W        = 50;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_MAP  = 1'b1
   } kind_type;

   typedef struct packed {
      logic               kind;
      logic [4:0]         cell_index;
      logic [1:0]         corner_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] edge_x;
      logic signed [15:0] edge_y;
      logic [15:0]        target_x;
      logic [15:0]        target_y;
   } req_word_type;

   typedef struct packed {
      logic [15:0] screen_x;
      logic [15:0] screen_y;
      logic        found;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] screen_y;
      logic [15:0] screen_x;
      logic [15:0] edge_y;
      logic [15:0] edge_x;
      logic [15:0] cam_y;
      logic [15:0] cam_x;
   } qgpw_entry_type;

   typedef struct packed {
      logic              mem_we;
      logic              capture_point;
      logic              scan_rd;
      logic [ADDR_W-1:0] scan_addr;
      logic              fetch_rd;
      logic [1:0]        fetch_k;
      logic              div_init;
      logic              div_step;
      logic              blend_mul;
      logic [1:0]        blend_k;
      logic              rsp_load;
   } qgpw_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } qgpw_status_type;

endpackage

### hdl/qgpw_ram.sv
// ----------------------------------------------------------------------------
// qgpw_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module qgpw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/qgpw_dp.sv
// ----------------------------------------------------------------------------
// qgpw_dp
// corner store, weight pipeline, ratio dividers, blend and result register
// ----------------------------------------------------------------------------
module qgpw_dp
   import qgpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_word_type    req_word,
   input  qgpw_cmd_type    cmd,
   output qgpw_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_word_type    rsp_word
);

   // corner store
   logic [8:0]        cell_ext;
   logic              wr_ok;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   qgpw_entry_type    wentry;
   qgpw_entry_type    rentry;
   logic [CELL_W-1:0] best_cell_ff;

   assign cell_ext = 9'(req_word.cell_index);
   assign wr_ok    = cell_ext < 9'(CELL_COUNT);
   assign waddr    = {cell_ext[CELL_W-1:0], req_word.corner_index};
   assign wentry   = '{screen_y: req_word.target_y, screen_x: req_word.target_x,
                       edge_y: req_word.edge_y, edge_x: req_word.edge_x,
                       cam_y: req_word.coord_y, cam_x: req_word.coord_x};
   assign raddr    = cmd.scan_rd ? cmd.scan_addr : {best_cell_ff, cmd.fetch_k};

   qgpw_ram #(
      .WIDTH($bits(qgpw_entry_type)),
      .DEPTH(CORNER_COUNT)
   ) u_ram (
      .clock(clock),
      .we(cmd.mem_we & wr_ok),
      .waddr(waddr),
      .wdata(wentry),
      .re(cmd.scan_rd | cmd.fetch_rd),
      .raddr(raddr),
      .rdata(rentry)
   );

   // weight pipeline
   logic signed [15:0] pt_x_ff, pt_y_ff;
   logic               s1_v_ff, s2_v_ff;
   logic [ADDR_W-1:0]  s1_addr_ff, s2_addr_ff;
   logic signed [16:0] dx, dy;
   logic signed [15:0] ex, ey;
   logic signed [32:0] p1, p2;
   logic signed [32:0] p1_ff, p2_ff;
   logic signed [W_W-1:0] w;
   logic [WU_W-1:0]    wc_ff [4];
   logic               ok_ff;
   logic               ok_now;
   logic [WU_W-1:0]    bw_ff [4];
   logic               found_ff;

   assign dx = {pt_x_ff[15], pt_x_ff} - {rentry.cam_x[15], rentry.cam_x};
   assign dy = {pt_y_ff[15], pt_y_ff} - {rentry.cam_y[15], rentry.cam_y};
   assign ex = rentry.edge_x;
   assign ey = rentry.edge_y;
   assign p1 = dx * ey;
   assign p2 = dy * ex;
   assign w  = W_W'(p1_ff) - W_W'(p2_ff);
   assign ok_now = (s2_addr_ff[1:0] == 2'd0) ? !w[W_W-1] : (ok_ff & !w[W_W-1]);

   always_ff @(posedge clock) begin
      if (cmd.capture_point) begin
         pt_x_ff <= req_word.coord_x;
         pt_y_ff <= req_word.coord_y;
      end
      s1_addr_ff <= cmd.scan_addr;
      s2_addr_ff <= s1_addr_ff;
      p1_ff      <= p1;
      p2_ff      <= p2;
      if (s2_v_ff) begin
         wc_ff[s2_addr_ff[1:0]] <= w[WU_W-1:0];
         ok_ff <= ok_now;
         if (s2_addr_ff[1:0] == 2'd3 && ok_now) begin
            bw_ff[0]     <= wc_ff[0];
            bw_ff[1]     <= wc_ff[1];
            bw_ff[2]     <= wc_ff[2];
            bw_ff[3]     <= w[WU_W-1:0];
            best_cell_ff <= s2_addr_ff[ADDR_W-1:2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_rd;
         s2_v_ff <= s1_v_ff;
         if (cmd.capture_point) begin
            found_ff <= 1'b0;
         end else if (s2_v_ff && s2_addr_ff[1:0] == 2'd3 && ok_now) begin
            found_ff <= 1'b1;
         end
      end
   end

   // ratio dividers, one quotient bit per step
   logic [DEN_W-1:0] den_x, den_y;
   logic [REM_W-1:0] rx_ff, ry_ff;
   logic [Q_W-1:0]   qx_ff, qy_ff;
   logic [REM_W-1:0] tx, ty;
   logic [REM_W-1:0] rx_sel, ry_sel;
   logic [Q_W-1:0]   wx, wy;

   assign den_x  = DEN_W'(bw_ff[0]) + DEN_W'(bw_ff[2]);
   assign den_y  = DEN_W'(bw_ff[1]) + DEN_W'(bw_ff[3]);
   assign tx     = rx_ff - REM_W'(den_x);
   assign ty     = ry_ff - REM_W'(den_y);
   assign rx_sel = tx[REM_W-1] ? rx_ff : tx;
   assign ry_sel = ty[REM_W-1] ? ry_ff : ty;
   assign wx     = (den_x == '0) ? '0 : qx_ff;
   assign wy     = (den_y == '0) ? '0 : qy_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rx_ff <= REM_W'(bw_ff[0]);
         ry_ff <= REM_W'(bw_ff[3]);
         qx_ff <= '0;
         qy_ff <= '0;
      end else if (cmd.div_step) begin
         rx_ff <= {rx_sel[REM_W-2:0], 1'b0};
         ry_ff <= {ry_sel[REM_W-2:0], 1'b0};
         qx_ff <= {qx_ff[Q_W-2:0], !tx[REM_W-1]};
         qy_ff <= {qy_ff[Q_W-2:0], !ty[REM_W-1]};
      end
   end

   // screen corners of the winning cell
   logic        f_v_ff;
   logic [1:0]  f_k_ff;
   logic [15:0] sx_ff [4];
   logic [15:0] sy_ff [4];

   always_ff @(posedge clock) begin
      f_k_ff <= cmd.fetch_k;
      if (f_v_ff) begin
         sx_ff[f_k_ff] <= rentry.screen_x;
         sy_ff[f_k_ff] <= rentry.screen_y;
      end
   end

   // blend: weight product, then screen multiply-accumulate
   logic [Q_W-1:0]   ix, iy, ma, mb;
   logic [33:0]      wp_ff;
   logic             a_v_ff;
   logic [1:0]       a_k_ff;
   logic [ACC_W-1:0] mx, my;
   logic [ACC_W-1:0] acc_x_ff, acc_y_ff;

   assign ix = Q_W'(1 << 16) - wx;
   assign iy = Q_W'(1 << 16) - wy;

   always_comb begin
      case (cmd.blend_k)
         2'd0:    begin ma = ix; mb = iy; end
         2'd1:    begin ma = ix; mb = wy; end
         2'd2:    begin ma = wx; mb = wy; end
         default: begin ma = wx; mb = iy; end
      endcase
   end

   assign mx = sx_ff[a_k_ff] * wp_ff;
   assign my = sy_ff[a_k_ff] * wp_ff;

   always_ff @(posedge clock) begin
      wp_ff  <= ma * mb;
      a_k_ff <= cmd.blend_k;
      if (cmd.div_init) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (a_v_ff) begin
         acc_x_ff <= acc_x_ff + mx;
         acc_y_ff <= acc_y_ff + my;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
      end else begin
         f_v_ff <= cmd.fetch_rd;
         a_v_ff <= cmd.blend_mul;
      end
   end

   // rounding, saturation and result register
   logic [ACC_W-1:0] rnd_x, rnd_y;
   logic [15:0]      sat_x, sat_y;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   assign rnd_x = acc_x_ff + (ACC_W'(1) << 31);
   assign rnd_y = acc_y_ff + (ACC_W'(1) << 31);
   assign sat_x = (|rnd_x[ACC_W-1:48]) ? 16'hFFFF : rnd_x[47:32];
   assign sat_y = (|rnd_y[ACC_W-1:48]) ? 16'hFFFF : rnd_y[47:32];

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff.screen_x <= found_ff ? sat_x : 16'd0;
         rsp_word_ff.screen_y <= found_ff ? sat_y : 16'd0;
         rsp_word_ff.found    <= found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule

### hdl/qgpw_ctrl.sv
// ----------------------------------------------------------------------------
// qgpw_ctrl
// sequencer for corner loads and the scan, divide and blend phases of a map
// ----------------------------------------------------------------------------
`include "quad_grid_point_warp_macros.svh"

module qgpw_ctrl
   import qgpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_kind,
   input  qgpw_status_type status,
   output qgpw_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV,
      ST_BLEND,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      cmd      = '0;
      cmd.scan_addr = cnt_ff[ADDR_W-1:0];
      cmd.fetch_k   = cnt_ff[1:0];
      cmd.blend_k   = cnt_ff[1:0];
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_kind == KIND_LOAD) begin
               cmd.mem_we = 1'b1;
            end else if (accept) begin
               cmd.capture_point = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == CNT_W'(CORNER_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_init = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            cmd.fetch_rd = (cnt_ff < CNT_W'(4));
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cmd.blend_mul = (cnt_ff < CNT_W'(4));
            if (cnt_ff == CNT_W'(4)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cnt_in = '0;
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `QGPW_ASSERT_IMPLIES(a_load_free, clock, reset, cmd.rsp_load, status.rsp_free, "result overwritten")
   `QGPW_ASSERT_IMPLIES(a_port_clash, clock, reset, cmd.mem_we, !cmd.scan_rd && !cmd.fetch_rd, "write during read phase")
   `QGPW_ASSERT_NEXT(a_map_start, clock, reset, accept && req_kind == KIND_MAP, state_ff == ST_SCAN, "map did not start scan")
   `QGPW_ASSERT_IMPLIES(a_ready_quiet, clock, reset, req_ready, !cmd.div_step && !cmd.blend_mul, "ready while busy")

endmodule

### hdl/quad_grid_point_warp.sv
// ----------------------------------------------------------------------------
// quad_grid_point_warp
// maps camera dot positions to screen positions through a grid of quads
// ----------------------------------------------------------------------------
// A load word (kind 0) writes one corner of one cell and gives no result;
// loads to a cell number beyond the grid are dropped. A map word (kind 1)
// gives one result word and occupies the block while the single read port
// of the corner store walks all 128 corner entries, followed by the
// bit-serial ratio dividers; no new word is taken until it is done. The
// corner store has no reset: every corner of every cell must be loaded
// before the first map.
// A finished result sits in an output register, so the next word is taken
// while the result waits; a map finishing with the register still full
// waits for it to drain.
module quad_grid_point_warp
   import qgpw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // command and status between sequencer and datapath
   qgpw_cmd_type    cmd;
   qgpw_status_type status;

   qgpw_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_word.kind),
      .status(status),
      .cmd(cmd)
   );

   // corner store, weight pipeline, dividers and blend
   qgpw_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_word(req_word),
      .cmd(cmd),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

endmodule
